// ===== sv/updt_pkg.sv =====
// updt_pkg: sizes, codes and types used by the udp port demux table;
// no dependencies
package updt_pkg;

  // table geometry and retry limit
  localparam int unsigned BUCKETS   = 256;
  localparam int unsigned WAYS      = 4;
  localparam int unsigned MAX_TRIES = 64;

  localparam int unsigned SLOTS  = BUCKETS * WAYS;
  localparam int unsigned BKT_W  = $clog2(BUCKETS);
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned TRY_W  = $clog2(MAX_TRIES + 1);

  // hash constants: ((HASH_INIT*HASH_MUL + addr)*HASH_MUL + port)
  localparam int unsigned HASH_INIT = 17;
  localparam int unsigned HASH_MUL  = 5;
  localparam logic [31:0] HASH_SEED = 32'(HASH_INIT * HASH_MUL * HASH_MUL);
  localparam int unsigned HASH_BITS = 32;
  localparam int unsigned HBIT_W    = $clog2(HASH_BITS);
  localparam bit BUCKET_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  localparam logic [15:0] EPHEMERAL_START = 16'd49152;

  typedef enum logic [1:0] {
    CMD_BIND    = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_LOOKUP  = 2'd2,
    CMD_EPHEM   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_IN_USE   = 3'd1,
    STS_NOT_REG  = 3'd2,
    STS_NO_MATCH = 3'd3,
    STS_FULL     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EPH,
    ST_HSUM,
    ST_HMOD,
    ST_ROW,
    ST_SCAN,
    ST_DONE
  } state_e;

  // one table entry
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [7:0]  sock;
  } slot_t;

  // network byte order swap of a 16-bit port
  function automatic logic [15:0] swap16(input logic [15:0] v);
    swap16 = {v[7:0], v[15:8]};
  endfunction

endpackage

// ===== sv/updt_ram.sv =====
// updt_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module updt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/udp_port_demux_table.sv =====
// udp_port_demux_table: hashed (address, port) to socket id table with
// bind, release, lookup and ephemeral port assignment; uses updt_pkg, updt_ram

// One request is worked on at a time; in_stall_o is high until its result has
// been handed to the output register, which can hold one result while the next
// request is taken. After reset the block stalls while the per-bucket valid
// rows are cleared. Every table probe goes through one sequencer: a state to
// form the 32-bit hash, a state to reduce it (a mask when BUCKETS is a power of
// two, else one remainder bit per cycle), a state for the bucket's valid row
// and first way, then the scan of the ways by the single shared key comparator
// (1 to WAYS ways). Bind and release take one probe and lookup one or two;
// ephemeral assignment takes, for each try, a candidate draw plus one probe,
// up to MAX_TRIES tries. A final state passes the result on to the output
// register, waiting while that register holds a result not yet taken.
module udp_port_demux_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] ip_address_i,
  input  logic [15:0] port_number_i,
  input  logic [7:0]  socket_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  found_socket_o,
  output logic [15:0] assigned_port_o
);
  import updt_pkg::*;

  // control state
  state_e            state_q, state_d;
  logic [BKT_W-1:0]  clr_q, clr_d;
  logic [15:0]       next_eph_q, next_eph_d;
  logic [TRY_W-1:0]  tries_q, tries_d;
  logic              second_q, second_d;
  logic              out_valid_q, out_valid_d;

  // request and working registers
  cmd_e              cmd_q, cmd_d;
  logic [7:0]        sock_q, sock_d;
  logic [31:0]       key_addr_q, key_addr_d;
  logic [15:0]       key_port_q, key_port_d;
  logic [31:0]       h_q, h_d;
  logic [BKT_W-1:0]  rem_q, rem_d;
  logic [HBIT_W-1:0] hbit_q, hbit_d;
  logic [BKT_W-1:0]  bucket_q, bucket_d;
  logic [SLOT_W-1:0] base_q, base_d;
  logic [WAY_W-1:0]  way_q, way_d;
  status_e           res_status_q, res_status_d;
  logic [7:0]        res_found_q, res_found_d;
  logic [15:0]       res_assigned_q, res_assigned_d;
  logic [2:0]        out_status_q, out_status_d;
  logic [7:0]        out_found_q, out_found_d;
  logic [15:0]       out_assigned_q, out_assigned_d;

  // ram ports
  logic              vr_we;
  logic [BKT_W-1:0]  vr_waddr;
  logic [WAYS-1:0]   vr_wdata;
  logic [WAYS-1:0]   vr_rdata;
  logic              sr_we;
  logic [SLOT_W-1:0] sr_waddr;
  slot_t             sr_wdata;
  logic [SLOT_W-1:0] sr_raddr;
  slot_t             sr_rdata;

  // shared datapath
  logic              way_valid;
  logic              key_match;
  logic              last_way;
  logic              free_found;
  logic [WAY_W-1:0]  free_way;
  logic [BKT_W:0]    mod_step;
  logic [TRY_W-1:0]  tries_inc;

  // valid rows, one bit per way, cleared after reset
  updt_ram #(
    .WIDTH (WAYS),
    .DEPTH (BUCKETS)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (vr_we),
    .waddr_i (vr_waddr),
    .wdata_i (vr_wdata),
    .raddr_i (bucket_q),
    .rdata_o (vr_rdata)
  );

  // entry payload, one slot per read
  updt_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (sr_we),
    .waddr_i (sr_waddr),
    .wdata_i (sr_wdata),
    .raddr_i (sr_raddr),
    .rdata_o (sr_rdata)
  );

  // key comparator for the way under test
  assign way_valid = vr_rdata[way_q];
  assign key_match = way_valid && (sr_rdata.addr == key_addr_q) &&
                     (sr_rdata.port == key_port_q);
  assign last_way  = (way_q == WAY_W'(WAYS - 1));
  assign tries_inc = tries_q + TRY_W'(1);

  // lowest free way of the bucket
  always_comb begin
    free_found = 1'b0;
    free_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vr_rdata[w]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
  end

  // one remainder bit of the hash modulo BUCKETS
  always_comb begin
    mod_step = {rem_q, h_q[HASH_BITS-1]};
    if (mod_step >= (BKT_W + 1)'(BUCKETS)) begin
      mod_step = mod_step - (BKT_W + 1)'(BUCKETS);
    end
  end

  // sequencer: next state, datapath control and ram writes
  always_comb begin
    state_d        = state_q;
    clr_d          = clr_q;
    next_eph_d     = next_eph_q;
    tries_d        = tries_q;
    second_d       = second_q;
    out_valid_d    = out_valid_q;
    cmd_d          = cmd_q;
    sock_d         = sock_q;
    key_addr_d     = key_addr_q;
    key_port_d     = key_port_q;
    h_d            = h_q;
    rem_d          = rem_q;
    hbit_d         = hbit_q;
    bucket_d       = bucket_q;
    base_d         = base_q;
    way_d          = way_q;
    res_status_d   = res_status_q;
    res_found_d    = res_found_q;
    res_assigned_d = res_assigned_q;
    out_status_d   = out_status_q;
    out_found_d    = out_found_q;
    out_assigned_d = out_assigned_q;
    vr_we          = 1'b0;
    vr_waddr       = bucket_q;
    vr_wdata       = vr_rdata;
    sr_we          = 1'b0;
    sr_waddr       = base_q + SLOT_W'(free_way);
    sr_wdata       = '{addr: key_addr_q, port: key_port_q, sock: sock_q};
    sr_raddr       = base_q + SLOT_W'(way_q) + SLOT_W'(1);
    in_stall_o     = 1'b1;

    // output register drains independently
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // zero every valid row
      ST_CLEAR: begin
        vr_we    = 1'b1;
        vr_waddr = clr_q;
        vr_wdata = '0;
        clr_d    = clr_q + BKT_W'(1);
        if (clr_q == BKT_W'(BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      // take a request
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_d          = cmd_e'(command_i);
          sock_d         = socket_number_i;
          key_addr_d     = ip_address_i;
          key_port_d     = port_number_i;
          second_d       = 1'b0;
          tries_d        = '0;
          res_found_d    = '0;
          res_assigned_d = '0;
          res_status_d   = STS_OK;
          state_d        = (cmd_e'(command_i) == CMD_EPHEM) ? ST_EPH : ST_HSUM;
        end
      end

      // draw the next ephemeral candidate
      ST_EPH: begin
        key_addr_d = '0;
        key_port_d = swap16(next_eph_q);
        next_eph_d = next_eph_q + 16'd1;
        state_d    = ST_HSUM;
      end

      // 32-bit wrapping hash sum
      ST_HSUM: begin
        h_d     = HASH_SEED + key_addr_q * 32'(HASH_MUL) + {16'd0, key_port_q};
        rem_d   = '0;
        hbit_d  = '0;
        state_d = ST_HMOD;
      end

      // bucket index: mask, or one remainder bit per cycle
      ST_HMOD: begin
        if (BUCKET_POW2) begin
          bucket_d = h_q[BKT_W-1:0];
          state_d  = ST_ROW;
        end else begin
          rem_d  = mod_step[BKT_W-1:0];
          h_d    = {h_q[HASH_BITS-2:0], 1'b0};
          hbit_d = hbit_q + HBIT_W'(1);
          if (hbit_q == HBIT_W'(HASH_BITS - 1)) begin
            bucket_d = mod_step[BKT_W-1:0];
            state_d  = ST_ROW;
          end
        end
      end

      // fetch valid row and first way
      ST_ROW: begin
        base_d   = SLOT_W'(bucket_q) * SLOT_W'(WAYS);
        sr_raddr = SLOT_W'(bucket_q) * SLOT_W'(WAYS);
        way_d    = '0;
        state_d  = ST_SCAN;
      end

      // compare one way per cycle and act on the outcome
      ST_SCAN: begin
        way_d = way_q + WAY_W'(1);
        if (key_match) begin
          state_d = ST_DONE;
          case (cmd_q)
            CMD_BIND: begin
              res_status_d = STS_IN_USE;
            end
            CMD_RELEASE: begin
              if (sr_rdata.sock == sock_q) begin
                vr_we        = 1'b1;
                vr_wdata     = vr_rdata & ~(WAYS'(1) << way_q);
                res_status_d = STS_OK;
              end else begin
                res_status_d = STS_NOT_REG;
              end
            end
            CMD_LOOKUP: begin
              res_status_d = STS_OK;
              res_found_d  = sr_rdata.sock;
            end
            CMD_EPHEM: begin
              tries_d = tries_inc;
              if (tries_inc == TRY_W'(MAX_TRIES)) begin
                res_status_d = STS_FULL;
              end else begin
                state_d = ST_EPH;
              end
            end
            default: begin
              res_status_d = STS_FULL;
            end
          endcase
        end else if (last_way) begin
          state_d = ST_DONE;
          case (cmd_q)
            CMD_BIND: begin
              if (free_found) begin
                sr_we        = 1'b1;
                vr_we        = 1'b1;
                vr_wdata     = vr_rdata | (WAYS'(1) << free_way);
                res_status_d = STS_OK;
              end else begin
                res_status_d = STS_FULL;
              end
            end
            CMD_RELEASE: begin
              res_status_d = STS_NOT_REG;
            end
            CMD_LOOKUP: begin
              if (!second_q) begin
                second_d   = 1'b1;
                key_addr_d = '0;
                state_d    = ST_HSUM;
              end else begin
                res_status_d = STS_NO_MATCH;
              end
            end
            CMD_EPHEM: begin
              if (key_port_q == 16'd0) begin
                res_status_d = STS_IN_USE;
              end else if (free_found) begin
                sr_we          = 1'b1;
                vr_we          = 1'b1;
                vr_wdata       = vr_rdata | (WAYS'(1) << free_way);
                res_status_d   = STS_OK;
                res_assigned_d = key_port_q;
              end else begin
                res_status_d = STS_FULL;
              end
            end
            default: begin
              res_status_d = STS_FULL;
            end
          endcase
        end
      end

      // hand the result to the output register
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d    = 1'b1;
          out_status_d   = res_status_q;
          out_found_d    = res_found_q;
          out_assigned_d = res_assigned_q;
          state_d        = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      next_eph_q  <= EPHEMERAL_START;
      tries_q     <= '0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      next_eph_q  <= next_eph_d;
      tries_q     <= tries_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q          <= cmd_d;
    sock_q         <= sock_d;
    key_addr_q     <= key_addr_d;
    key_port_q     <= key_port_d;
    h_q            <= h_d;
    rem_q          <= rem_d;
    hbit_q         <= hbit_d;
    bucket_q       <= bucket_d;
    base_q         <= base_d;
    way_q          <= way_d;
    res_status_q   <= res_status_d;
    res_found_q    <= res_found_d;
    res_assigned_q <= res_assigned_d;
    out_status_q   <= out_status_d;
    out_found_q    <= out_found_d;
    out_assigned_q <= out_assigned_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign found_socket_o  = out_found_q;
  assign assigned_port_o = out_assigned_q;

endmodule
